[hdl/ffba_pkg.sv]
// Shared types and constants for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam int NUM_BLOCKS = 4096;
    localparam int SIZE_W     = 19;
    localparam int INDEX_W    = 12;
    localparam int LEN_W      = 13;
    localparam int WORD_W     = 64;

    localparam logic [0:0] REG_HEAP_BLOCKS = 1'b0;

endpackage

[hdl/ffba_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[hdl/first_fit_block_allocator_core.sv]
// Top level of the first-fit block allocator with coalescing.
// Depends on ffba_pkg and ffba_ram.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid/s_ready   | s_req_type, s_size_bytes, s_free_index
//  m_      | out | m_valid/m_ready   | m_status, m_start_index, m_blocks_granted
//  apb     | in  | psel/penable      | paddr, pwdata, prdata (heap_blocks)
//
// An allocate first takes the request and works out the block count, then scans the
// used map one block per cycle, pausing to read each new 64-block word, up to the
// smaller of heap_blocks and NUM_BLOCKS. A grant or a free then updates one block per
// cycle, reading and writing back each word touched, and records the run. The result
// is registered in S_DONE and s_ready returns the cycle after it is taken. After reset
// a clearing pass over every block holds s_ready low.
module first_fit_block_allocator_core #(
    parameter int BLOCK_BYTES  = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [ffba_pkg::SIZE_W-1:0]    s_size_bytes,
    input  logic [ffba_pkg::INDEX_W-1:0]   s_free_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [ffba_pkg::INDEX_W-1:0]   m_start_index,
    output logic [ffba_pkg::LEN_W-1:0]     m_blocks_granted,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ffba_pkg::*;

    localparam int AW    = $clog2(NUM_BLOCKS);
    localparam int CW    = AW + 1;
    localparam int WORDS = NUM_BLOCKS / WORD_W;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(WORD_W);
    localparam int NEEDW = SIZE_W + 1;
    localparam int RLW   = LEN_W + 1;
    localparam int PW    = 2 * NEEDW + 1;
    // For any x below 2**NEEDW, x / BLOCK_BYTES equals (x * RMUL) >> RSH.
    localparam int     RSH  = NEEDW + $clog2(BLOCK_BYTES);
    localparam longint RMUL = ((longint'(1) << RSH) + longint'(BLOCK_BYTES) - 1)
                              / longint'(BLOCK_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_RD, S_SCAN, S_FRD, S_FCHK,
        S_LD, S_GET, S_SET, S_WB, S_REC, S_DONE
    } state_t;

    state_t state_reg;
    logic [LEN_W-1:0]  heap_reg;
    logic              type_reg;
    logic [NEEDW-1:0]  rem_reg;
    logic [NEEDW-1:0]  need_reg;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     start_reg;
    logic [CW-1:0]     left_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WAW-1:0]    waddr_reg;
    logic [1:0]        st_reg;
    logic [LEN_W-1:0]  len_reg;

    // Used map memory, one 64-bit word per row.
    logic              um_we;
    logic [WAW-1:0]    um_addr;
    logic [WORD_W-1:0] um_wdata, um_rdata;
    ffba_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_used (
        .aclk(aclk), .we(um_we), .addr(um_addr), .wdata(um_wdata), .rdata(um_rdata)
    );

    // Start mark and run length of each block; the mark is the top bit.
    logic             rl_we;
    logic [AW-1:0]    rl_addr;
    logic [RLW-1:0]   rl_wdata, rl_rdata;
    ffba_ram #(.WIDTH(RLW), .DEPTH(NUM_BLOCKS)) u_len (
        .aclk(aclk), .we(rl_we), .addr(rl_addr),
        .wdata(rl_wdata), .rdata(rl_rdata)
    );

    logic [CW-1:0] lim;
    assign lim = (heap_reg < LEN_W'(NUM_BLOCKS)) ? CW'(heap_reg) : CW'(NUM_BLOCKS);

    logic [BW-1:0] bit_sel;
    assign bit_sel = pos_reg[BW-1:0];

    logic [PW-1:0] quot_prod;
    assign quot_prod = PW'(rem_reg) * PW'(RMUL);

    always_comb begin
        um_we    = 1'b0;
        um_addr  = pos_reg[AW-1:BW];
        um_wdata = word_reg;
        rl_we    = 1'b0;
        rl_addr  = start_reg[AW-1:0];
        rl_wdata = {type_reg == REQ_ALLOC, len_reg};
        case (state_reg)
            S_CLEAR: begin
                um_we    = 1'b1;
                um_wdata = '0;
                rl_we    = 1'b1;
                rl_addr  = pos_reg[AW-1:0];
                rl_wdata = '0;
            end
            S_WB: begin
                um_we   = 1'b1;
                um_addr = waddr_reg;
            end
            S_REC:   rl_we = 1'b1;
            default: ;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_HEAP_BLOCKS) ? {{(32-LEN_W){1'b0}}, heap_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            heap_reg  <= LEN_W'(4096);
            pos_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_HEAP_BLOCKS) begin
                heap_reg <= pwdata[LEN_W-1:0];
            end
            case (state_reg)
                S_CLEAR: begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == CW'(NUM_BLOCKS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        type_reg  <= s_req_type;
                        pos_reg   <= '0;
                        count_reg <= '0;
                        rem_reg   <= NEEDW'(s_size_bytes) + NEEDW'(HEADER_BYTES);
                        start_reg <= CW'(s_free_index);
                        st_reg    <= ST_OK;
                        if (s_req_type == REQ_FREE) begin
                            state_reg <= S_FRD;
                        end else if (s_size_bytes == '0) begin
                            st_reg    <= ST_ZERO;
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                // Block count by reciprocal multiplication, exact over the whole range.
                S_DIV: begin
                    need_reg  <= NEEDW'(quot_prod >> RSH) + NEEDW'(1);
                    state_reg <= S_RD;
                end
                S_RD: begin
                    if (pos_reg >= lim) begin
                        st_reg    <= ST_NOFIT;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (pos_reg >= lim) begin
                        st_reg    <= ST_NOFIT;
                        state_reg <= S_DONE;
                    end else if (um_rdata[bit_sel]) begin
                        count_reg <= '0;
                        pos_reg   <= pos_reg + 1'b1;
                        if (bit_sel == BW'(WORD_W - 1)) state_reg <= S_RD;
                    end else if (NEEDW'(count_reg) + NEEDW'(1) >= need_reg) begin
                        start_reg <= pos_reg + 1'b1 - need_reg[CW-1:0];
                        pos_reg   <= pos_reg + 1'b1 - need_reg[CW-1:0];
                        left_reg  <= need_reg[CW-1:0];
                        len_reg   <= need_reg[LEN_W-1:0];
                        state_reg <= S_LD;
                    end else begin
                        count_reg <= count_reg + 1'b1;
                        pos_reg   <= pos_reg + 1'b1;
                        if (bit_sel == BW'(WORD_W - 1)) state_reg <= S_RD;
                    end
                end
                S_FRD: state_reg <= S_FCHK;
                S_FCHK: begin
                    if (!rl_rdata[LEN_W]) begin
                        st_reg    <= ST_BADFREE;
                        state_reg <= S_DONE;
                    end else begin
                        len_reg   <= rl_rdata[LEN_W-1:0];
                        left_reg  <= CW'(rl_rdata[LEN_W-1:0]);
                        pos_reg   <= start_reg;
                        state_reg <= S_LD;
                    end
                end
                // Read-modify-write of the used words that the run covers.
                S_LD: begin
                    if (left_reg == '0) begin
                        state_reg <= S_REC;
                    end else begin
                        waddr_reg <= pos_reg[AW-1:BW];
                        state_reg <= S_GET;
                    end
                end
                S_GET: begin
                    word_reg  <= um_rdata;
                    state_reg <= S_SET;
                end
                S_SET: begin
                    word_reg[bit_sel] <= (type_reg == REQ_ALLOC);
                    pos_reg  <= pos_reg + 1'b1;
                    left_reg <= left_reg - 1'b1;
                    if (left_reg == CW'(1) || bit_sel == BW'(WORD_W - 1)) begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:  state_reg <= S_LD;
                S_REC: state_reg <= S_DONE;
                S_DONE: begin
                    if (!m_valid) begin
                        m_valid          <= 1'b1;
                        m_status         <= st_reg;
                        m_start_index    <= (st_reg == ST_OK) ? start_reg[INDEX_W-1:0] : '0;
                        m_blocks_granted <= (st_reg == ST_OK) ? len_reg : '0;
                    end else if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/ffba_checker.sv]
// Port-level checker for the first-fit block allocator, with its bind.
// Depends on ffba_pkg.
module ffba_assert_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [11:0] m_start_index,
    input logic [12:0] m_blocks_granted
);
    import ffba_pkg::*;

    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_start_index == '0 && m_blocks_granted == '0))
        else $error("error result carries data");
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |-> m_blocks_granted != '0)
        else $error("ok result with zero length");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready right after accept");
endmodule

bind first_fit_block_allocator_core ffba_assert_checker u_ffba_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_start_index(m_start_index), .m_blocks_granted(m_blocks_granted)
);

[verif/ffba_checker.sv]
// Result checker for the first-fit block allocator: watches the request, result and
// APB channels, keeps its own block map and heap size, and compares each result item.
// Depends on ffba_pkg.
module ffba_checker #(
    parameter int NUM_BLOCKS   = 4096,
    parameter int BLOCK_BYTES  = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [ffba_pkg::SIZE_W-1:0]  s_size_bytes,
    input  logic [ffba_pkg::INDEX_W-1:0] s_free_index,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [1:0]                   m_status,
    input  logic [ffba_pkg::INDEX_W-1:0] m_start_index,
    input  logic [ffba_pkg::LEN_W-1:0]   m_blocks_granted,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output int                           fail_count,
    output int                           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffba_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } grant_t;

    grant_t  grant_q[$];
    logic    used_map[NUM_BLOCKS];
    logic    live_start[NUM_BLOCKS];
    int      live_len[NUM_BLOCKS];
    int      heap_size;

    function automatic grant_t do_allocate(int unsigned size);
        grant_t g;
        int unsigned need;
        int lim;
        int run;
        int first;
        g = '0;
        if (size == 0) begin
            g.status = ST_ZERO;
            return g;
        end
        need = (size + HEADER_BYTES) / BLOCK_BYTES + 1;
        lim = (heap_size < NUM_BLOCKS) ? heap_size : NUM_BLOCKS;
        run = 0;
        for (int i = 0; i < lim; i++) begin
            if (used_map[i]) begin
                run = 0;
            end else begin
                run++;
                if (run >= need) begin
                    first = i + 1 - need;
                    for (int k = first; k <= i; k++) used_map[k] = 1'b1;
                    live_start[first] = 1'b1;
                    live_len[first] = need;
                    g.status = ST_OK;
                    g.start = first[INDEX_W-1:0];
                    g.len = need[LEN_W-1:0];
                    return g;
                end
            end
        end
        g.status = ST_NOFIT;
        return g;
    endfunction

    function automatic grant_t do_release(int idx);
        grant_t g;
        g = '0;
        if (!live_start[idx]) begin
            g.status = ST_BADFREE;
            return g;
        end
        for (int k = 0; k < live_len[idx] && idx + k < NUM_BLOCKS; k++)
            used_map[idx + k] = 1'b0;
        live_start[idx] = 1'b0;
        g.status = ST_OK;
        g.start = idx[INDEX_W-1:0];
        g.len = live_len[idx][LEN_W-1:0];
        return g;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            grant_q.delete();
            heap_size <= 4096;
            fail_count = 0;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                used_map[i] = 1'b0;
                live_start[i] = 1'b0;
                live_len[i] = 0;
            end
        end else begin
            if (psel && penable && pwrite && paddr == {REG_HEAP_BLOCKS, 2'b00})
                heap_size <= int'(32'(pwdata[12:0]));
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_ALLOC) grant_q.push_back(do_allocate(32'(s_size_bytes)));
                else grant_q.push_back(do_release(int'(32'(s_free_index))));
            end
            if (m_valid && m_ready) begin
                if (grant_q.size() == 0) begin
                    $display("%0t result item with nothing expected", $realtime);
                    fail_count++;
                end else begin
                    want = grant_q.pop_front();
                    if (m_status !== want.status)
                        report("status", int'(32'(m_status)), int'(32'(want.status)));
                    if (m_start_index !== want.start)
                        report("start_index", int'(32'(m_start_index)),
                               int'(32'(want.start)));
                    if (m_blocks_granted !== want.len)
                        report("blocks_granted", int'(32'(m_blocks_granted)),
                               int'(32'(want.len)));
                end
            end
        end
        pending_count <= grant_q.size();
    end
endmodule

[verif/tb_first_fit_block_allocator_core.sv]
// Top of the allocator testbench: clock, reset, APB writes, request stimulus
// and the verdict. Depends on ffba_pkg, ffba_checker and the allocator core.
module tb_first_fit_block_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ffba_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_req_type;
    logic [SIZE_W-1:0]  s_size_bytes;
    logic [INDEX_W-1:0] s_free_index;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic [INDEX_W-1:0] m_start_index;
    logic [LEN_W-1:0]   m_blocks_granted;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending_count;
    int                 idle_cycles;
    int unsigned        grant_starts[$];

    first_fit_block_allocator_core dut (.*);

    ffba_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_size_bytes,
        .s_free_index, .m_valid, .m_ready, .m_status, .m_start_index,
        .m_blocks_granted, .psel, .penable, .pwrite, .paddr, .pwdata,
        .fail_count, .pending_count
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Remember granted starts so that random frees mostly hit live runs.
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_status == ST_OK)
            grant_starts.push_back(32'(m_start_index));
    end

    // The receiver stalls on its own pattern: long free-running, then choppy.
    always @(posedge aclk) begin
        int unsigned phase;
        if (!aresetn) begin
            m_ready <= 1'b0;
            phase = 0;
        end else begin
            phase++;
            if (phase % 512 < 200) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic apb_write(logic [12:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_HEAP_BLOCKS, 2'b00};
        pwdata <= {19'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Valid stays high after an accept unless a gap follows, so the next
    // item can take over at the same edge.
    task automatic send_request(logic kind, logic [SIZE_W-1:0] size, logic [INDEX_W-1:0] idx);
        int gap;
        // A gap before roughly one item in four forms the bursts.
        if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_size_bytes <= size;
        s_free_index <= idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Idle point: all results back, then enough cycles for any tail work.
    task automatic drain;
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0 || m_valid);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_requests(int count, int max_size);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_request(REQ_ALLOC, SIZE_W'($urandom_range(1, max_size)),
                             INDEX_W'($urandom));
            end else if (pick < 85 && grant_starts.size() > 0) begin
                pick = $urandom_range(0, grant_starts.size() - 1);
                send_request(REQ_FREE, SIZE_W'($urandom), INDEX_W'(grant_starts[pick]));
                grant_starts.delete(pick);
            end else if (pick < 95) begin
                send_request(REQ_FREE, SIZE_W'($urandom), INDEX_W'($urandom));
            end else begin
                send_request(REQ_ALLOC, (pick & 1) ? 19'd0 : {SIZE_W{1'b1}},
                             INDEX_W'($urandom));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = REQ_ALLOC;
        s_size_bytes = '0;
        s_free_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero size, the largest sizes, a bad free, double free, a free of an unused block.
        send_request(REQ_ALLOC, 19'd0, 12'hFFF);
        send_request(REQ_ALLOC, 19'd1, 12'd0);
        send_request(REQ_ALLOC, 19'd39, 12'd0);
        send_request(REQ_ALLOC, 19'd40, 12'd0);
        send_request(REQ_FREE, {SIZE_W{1'b1}}, 12'd2);
        send_request(REQ_FREE, 19'd0, 12'd1);
        send_request(REQ_FREE, 19'd0, 12'd1);
        send_request(REQ_ALLOC, 19'd100, 12'd0);
        send_request(REQ_ALLOC, 19'd262144, 12'd0);
        send_request(REQ_FREE, 19'd0, 12'hFFF);
        send_request(REQ_ALLOC, {SIZE_W{1'b1}}, 12'd0);
        send_request(REQ_FREE, 19'd0, 12'd0);
        send_request(REQ_FREE, 19'd0, 12'd3);
        drain();
        grant_starts.delete();

        // A small heap below live runs; those runs must still free.
        apb_write(13'd16);
        send_request(REQ_ALLOC, 19'd1000, 12'd0);
        send_request(REQ_ALLOC, 19'd1, 12'd0);
        send_request(REQ_FREE, 19'd0, 12'd1);
        send_request(REQ_FREE, 19'd0, 12'd3);
        drain();
        apb_write(13'd0);
        send_request(REQ_ALLOC, 19'd1, 12'd0);
        drain();
        apb_write(13'd1);
        send_request(REQ_ALLOC, 19'd1, 12'd0);
        send_request(REQ_ALLOC, 19'd1, 12'd0);
        send_request(REQ_ALLOC, 19'd50, 12'd0);
        drain();
        grant_starts.delete();
        // Clean out what the directed part left live.
        apb_write(13'd4096);
        for (int i = 0; i < 64; i++) send_request(REQ_FREE, 19'd0, i[11:0]);
        drain();

        apb_write(13'd64);
        random_requests(500, 600);
        drain();
        apb_write(13'h1FFF);
        random_requests(250, 262144);
        drain();
        apb_write(13'd200);
        random_requests(450, 2000);
        drain();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[files.f]
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/first_fit_block_allocator_core.sv
hdl/ffba_checker.sv
verif/ffba_checker.sv
verif/tb_first_fit_block_allocator_core.sv
